[design/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions of the byte-stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Width of the message bit counter, 32 to 64.
  localparam int unsigned LenBits = 64;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_EMIT_RD,
    S_EMIT_CAP
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_ph_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    unique case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[i];
  endfunction

endpackage

[design/sha_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Hashes a byte stream and returns the eight digest words at end of message.
// ----------------------------------------------------------------------------
//  Channel  Signals                                         Direction
//  request  in_valid_i, in_stall_o, msg_byte_i,
//           byte_valid_i, end_of_message_i                  in
//  result   out_valid_o, out_stall_i, digest_word_o,
//           word_index_o, last_word_o                       out
//
// A full block is compressed by a load from the block and hash memories, 64
// rounds and a read-add-write on the hash memory. Padding pushes one byte per
// cycle, pausing while a full block is compressed, and each digest word is read
// from the hash memory in S_EMIT_RD and captured in S_EMIT_CAP.
// Reset returns the hash words to the initial values through valid bits.
// A stalled last digest word waits in the output register while new requests are taken.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_pkg::state_e  state_q, state_d, ret_q, ret_d;
  sha_pkg::pad_ph_e ph_q, ph_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [5:0]  fill_q, fill_d;
  logic [23:0] part_q, part_d;
  logic [sha_pkg::LenBits-1:0] bits_q, bits_d;
  logic [7:0]  hv_q, hv_d;
  logic [2:0]  hr_idx_q;
  logic        hr_iv_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic        out_v_q, out_v_d;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  logic        accept;
  logic        push_v;
  logic [7:0]  push_b;
  logic        blk_we;
  logic [31:0] blk_rdata, hash_rdata, hdata, hash_wdata;
  logic        hash_we;
  logic [2:0]  hash_waddr;
  logic        len_sel;
  logic [63:0] len64;
  logic [2:0]  len_idx;
  logic [7:0]  len_byte;
  logic        out_load;
  logic [31:0] t1, t2, w_new;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != sha_pkg::S_IDLE);

  assign len64 = 64'(bits_q);
  assign len_idx = 3'd7 - fill_q[2:0];
  assign len_byte = len64[{len_idx, 3'b000} +: 8];
  assign len_sel = (ph_q == sha_pkg::PH_LEN) ||
                   ((ph_q == sha_pkg::PH_ZERO) && (fill_q == sha_pkg::LenOffset));

  assign hdata = hr_iv_q ? sha_pkg::init_h(hr_idx_q) : hash_rdata;

  assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) +
              ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
              sha_pkg::round_k(cnt_q[5:0]) + w_q[0];
  assign t2 = sha_pkg::bsig0(v_q[0]) +
              ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = w_q[0] + sha_pkg::ssig0(w_q[1]) + w_q[9] + sha_pkg::ssig1(w_q[14]);

  // Datapath controls.
  always_comb begin
    push_v     = 1'b0;
    push_b     = 8'h00;
    hash_we    = 1'b0;
    hash_waddr = 3'(cnt_q - 7'd1);
    hash_wdata = hdata + v_q[0];
    out_load   = 1'b0;
    unique case (state_q)
      sha_pkg::S_IDLE: begin
        push_v = accept && byte_valid_i;
        push_b = msg_byte_i;
      end
      sha_pkg::S_PAD: begin
        push_v = 1'b1;
        if (ph_q == sha_pkg::PH_MARK) begin
          push_b = sha_pkg::PadMark;
        end else if (len_sel) begin
          push_b = len_byte;
        end
      end
      sha_pkg::S_FINAL: begin
        hash_we = (cnt_q != 7'd0);
      end
      sha_pkg::S_EMIT_CAP: begin
        out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign blk_we = push_v && (fill_q[1:0] == 2'd3);
  assign part_d = push_v ? {part_q[15:0], push_b} : part_q;
  assign fill_d = push_v ? fill_q + 6'd1 : fill_q;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    hv_d    = hv_q;
    out_v_d = out_v_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (out_load) begin
      out_v_d = 1'b1;
    end
    if (hash_we) begin
      hv_d[hash_waddr] = 1'b1;
    end
    unique case (state_q)
      sha_pkg::S_IDLE: begin
        if (accept) begin
          ph_d = sha_pkg::PH_MARK;
          if (byte_valid_i) begin
            bits_d = bits_q + sha_pkg::LenBits'(8);
          end
          if (byte_valid_i && (fill_q == 6'd63)) begin
            state_d = sha_pkg::S_LOAD;
            cnt_d   = '0;
            ret_d   = end_of_message_i ? sha_pkg::S_PAD : sha_pkg::S_IDLE;
          end else if (end_of_message_i) begin
            state_d = sha_pkg::S_PAD;
          end
        end
      end
      sha_pkg::S_PAD: begin
        if (ph_q == sha_pkg::PH_MARK) begin
          ph_d = sha_pkg::PH_ZERO;
        end else if (len_sel) begin
          ph_d = sha_pkg::PH_LEN;
        end
        if (fill_q == 6'd63) begin
          state_d = sha_pkg::S_LOAD;
          cnt_d   = '0;
          ret_d   = (len_sel && ph_q != sha_pkg::PH_MARK) ? sha_pkg::S_EMIT_RD
                                                          : sha_pkg::S_PAD;
        end
      end
      sha_pkg::S_LOAD: begin
        if (cnt_q == 7'd16) begin
          state_d = sha_pkg::S_ROUND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      sha_pkg::S_ROUND: begin
        if (cnt_q == 7'd63) begin
          state_d = sha_pkg::S_FINAL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      sha_pkg::S_FINAL: begin
        if (cnt_q == 7'd8) begin
          state_d = ret_q;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      sha_pkg::S_EMIT_RD: begin
        if (!out_v_q || !out_stall_i) begin
          state_d = sha_pkg::S_EMIT_CAP;
        end
      end
      sha_pkg::S_EMIT_CAP: begin
        if (cnt_q == 7'd7) begin
          // Digest is out: start the next message from the initial values.
          state_d = sha_pkg::S_IDLE;
          cnt_d   = '0;
          hv_d    = '0;
          bits_d  = '0;
        end else begin
          state_d = sha_pkg::S_EMIT_RD;
          cnt_d   = cnt_q + 7'd1;
        end
      end
      default: begin
        state_d = sha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::S_IDLE;
      ret_q   <= sha_pkg::S_IDLE;
      ph_q    <= sha_pkg::PH_MARK;
      cnt_q   <= '0;
      fill_q  <= '0;
      bits_q  <= '0;
      hv_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      hv_q    <= hv_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q   <= part_d;
    hr_idx_q <= cnt_q[2:0];
    hr_iv_q  <= !hv_q[cnt_q[2:0]];
    if (out_load) begin
      out_word_q <= hdata;
      out_idx_q  <= cnt_q[2:0];
      out_last_q <= (cnt_q == 7'd7);
    end
    if (state_q == sha_pkg::S_LOAD && cnt_q != 7'd0) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= blk_rdata;
      if (cnt_q <= 7'd8) begin
        for (int i = 0; i < 7; i++) begin
          v_q[i] <= v_q[i + 1];
        end
        v_q[7] <= hdata;
      end
    end else if (state_q == sha_pkg::S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (hash_we) begin
      for (int i = 0; i < 7; i++) begin
        v_q[i] <= v_q[i + 1];
      end
    end
  end

  sha_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (blk_we),
    .waddr_i(fill_q[5:2]),
    .wdata_i({part_q, push_b}),
    .raddr_i(cnt_q[3:0]),
    .rdata_o(blk_rdata)
  );

  sha_ram #(
    .WIDTH(32),
    .DEPTH(8)
  ) u_hash_ram (
    .clk_i  (clk_i),
    .we_i   (hash_we),
    .waddr_i(hash_waddr),
    .wdata_i(hash_wdata),
    .raddr_i(cnt_q[2:0]),
    .rdata_o(hash_rdata)
  );

  assign out_valid_o   = out_v_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

  // A block is only compressed once it is full, so the fill has wrapped.
  a_final_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pkg::S_FINAL) |-> (fill_q == 6'd0))
    else $error("hash update with a partly filled block");

  // A digest word is never loaded over a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_v_q && out_stall_i))
    else $error("output register overwritten");

  // After the last word the hash words read as initial values again.
  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cnt_q == 7'd7) |=> (hv_q == 8'h00 && state_q == sha_pkg::S_IDLE))
    else $error("hash words not reinitialized");

endmodule
